@@ rtl/core/sisr_pkg.sv @@
`timescale 1ns / 1ps

package sisr_pkg;

  localparam int NODE_FIELD_W = 6;
  localparam int PROB_FIELD_W = 16;
  localparam int CNT_CFG_W    = 7;
  localparam logic [CNT_CFG_W-1:0] NODE_COUNT_RESET = 7'd62;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_DRAW  = 2'd3;

  localparam logic [1:0] KIND_NODE = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [NODE_FIELD_W-1:0] node;
    logic [NODE_FIELD_W-1:0] neighbor;
    logic [PROB_FIELD_W-1:0] infect_prob;
    logic [PROB_FIELD_W-1:0] recover_prob;
    logic                    initial_state;
    logic [PROB_FIELD_W-1:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [NODE_FIELD_W-1:0] result_node;
    logic                    new_state;
    logic                    last_of_round;
    logic                    any_infected;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted transaction
    logic rd_item;   // read stores at the item's node, else at the cursor
    logic load;      // write node tables and emit the ack
    logic edge_wr;   // append the neighbor
    logic start;     // open a round
    logic step;      // advance within a node, no result
    logic finish;    // resolve the cursor node and emit its result
    logic fin_draw;  // finish value comes from the draw, else zero
    logic emit_err;  // emit an error result
  } sisr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       active;
    logic       bad_load;
    logic       bad_edge;
    logic       step_done;
    logic       skip_ok;
    logic       out_free;
  } sisr_sts_t;

endpackage

@@ rtl/core/sisr_ctrl.sv @@
`timescale 1ns / 1ps

module sisr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sisr_pkg::sisr_sts_t sts,
  output sisr_pkg::sisr_cmd_t cmd
);
  import sisr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EXEC, S_SCAN_RD, S_SCAN_EV
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_item = (sts.op == OP_LOAD) || (sts.op == OP_EDGE);
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts.op)
          OP_LOAD: begin
            if (sts.out_free) begin
              cmd.emit_err = sts.bad_load;
              cmd.load     = !sts.bad_load;
              state_nxt    = S_IDLE;
            end
          end
          OP_EDGE: begin
            if (!sts.bad_edge) begin
              cmd.edge_wr = 1'b1;
              state_nxt   = S_IDLE;
            end else if (sts.out_free) begin
              cmd.emit_err = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          OP_START: begin
            cmd.start = 1'b1;
            state_nxt = S_SCAN_RD;
          end
          default: begin
            if (!sts.active) begin
              if (sts.out_free) begin
                cmd.emit_err = 1'b1;
                state_nxt    = S_IDLE;
              end
            end else if (!sts.step_done) begin
              cmd.step  = 1'b1;
              state_nxt = S_IDLE;
            end else if (sts.out_free) begin
              cmd.finish   = 1'b1;
              cmd.fin_draw = 1'b1;
              state_nxt    = S_SCAN_RD;
            end
          end
        endcase
      end
      S_SCAN_RD: state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        if (!sts.skip_ok) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_SCAN_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/sisr_dp.sv @@
`timescale 1ns / 1ps

module sisr_dp #(
  parameter int MAX_NODES  = 64,
  parameter int MAX_DEGREE = 64,
  parameter int PROB_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sisr_pkg::in_item_t              in_data,
  input  logic [sisr_pkg::CNT_CFG_W-1:0]  node_count,
  input  sisr_pkg::sisr_cmd_t             cmd,
  output sisr_pkg::sisr_sts_t             sts,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sisr_pkg::out_item_t             out_data
);
  import sisr_pkg::*;

  localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int DW   = $clog2(MAX_DEGREE + 1);
  localparam int CNTW = $clog2(MAX_NODES + 1);
  localparam int AW   = $clog2(MAX_NODES * MAX_DEGREE);

  logic [PROB_BITS-1:0] infect_mem  [MAX_NODES];
  logic [PROB_BITS-1:0] recover_mem [MAX_NODES];
  logic [DW-1:0]        deg_mem     [MAX_NODES];
  logic [NW-1:0]        nbr_mem     [MAX_NODES*MAX_DEGREE];

  in_item_t             item_r;
  logic [MAX_NODES-1:0] dvld_r, cur_r, next_r;
  logic [NW-1:0]        cursor_r;
  logic [DW-1:0]        edge_r;
  logic                 caught_r, active_r, seen_r;
  logic [PROB_BITS-1:0] infect_q_r, recover_q_r;
  logic [DW-1:0]        deg_q_r;
  logic                 dvld_q_r;
  logic [NW-1:0]        nbr_q_r;
  logic                 out_valid_r;
  out_item_t            out_r;

  logic [NW-1:0]        ndi, rd_addr, who;
  logic [AW-1:0]        nbr_rd_addr, nbr_wr_addr;
  logic [DW-1:0]        deg_eff, edge_inc;
  logic [CNTW-1:0]      n_act;
  logic [PROB_BITS-1:0] rv_p;
  logic                 cur_bit, draw_hit, caught_nx, fin_val, fin_v, last, seen_nx;
  logic [MAX_NODES-1:0] next_mix;
  logic                 out_free;

  always_comb begin
    if (node_count == '0) begin
      n_act = CNTW'(1);
    end else if (int'(node_count) > MAX_NODES) begin
      n_act = CNTW'(MAX_NODES);
    end else begin
      n_act = CNTW'(node_count);
    end
  end

  assign ndi         = NW'(item_r.node);
  assign rd_addr     = cmd.rd_item ? ndi : cursor_r;
  assign nbr_rd_addr = AW'(cursor_r) * AW'(MAX_DEGREE) + AW'(edge_r);
  assign deg_eff     = dvld_q_r ? deg_q_r : '0;
  assign nbr_wr_addr = AW'(ndi) * AW'(MAX_DEGREE) + AW'(deg_eff);
  assign rv_p        = PROB_BITS'(item_r.random_value);
  assign cur_bit     = cur_r[cursor_r];
  assign who         = nbr_q_r;
  assign draw_hit    = rv_p < infect_q_r;
  assign caught_nx   = caught_r | (draw_hit & cur_r[who]);
  assign edge_inc    = edge_r + DW'(1);
  assign fin_val     = cur_bit ? !(rv_p < recover_q_r) : caught_nx;
  assign fin_v       = cmd.fin_draw ? fin_val : 1'b0;
  assign last        = (int'(cursor_r) + 1) >= int'(n_act);
  assign seen_nx     = seen_r | fin_v;
  assign out_free    = !out_valid_r || !out_stall;

  always_comb begin
    next_mix           = next_r;
    next_mix[cursor_r] = fin_v;
  end

  always_comb begin
    sts.op        = item_r.opcode;
    sts.active    = active_r;
    sts.bad_load  = active_r || (int'(item_r.node) >= MAX_NODES);
    sts.bad_edge  = active_r || (int'(item_r.node) >= MAX_NODES) ||
                    (int'(item_r.neighbor) >= MAX_NODES) ||
                    (int'(deg_eff) >= MAX_DEGREE);
    sts.step_done = cur_bit || (edge_inc >= deg_eff);
    sts.skip_ok   = active_r && !cur_bit && (deg_eff == '0);
    sts.out_free  = out_free;
  end

  // Stores and registered reads
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      infect_mem[ndi]  <= PROB_BITS'(item_r.infect_prob);
      recover_mem[ndi] <= PROB_BITS'(item_r.recover_prob);
      deg_mem[ndi]     <= '0;
    end
    if (cmd.edge_wr) begin
      nbr_mem[nbr_wr_addr] <= NW'(item_r.neighbor);
      deg_mem[ndi]         <= deg_eff + DW'(1);
    end
    infect_q_r  <= infect_mem[rd_addr];
    recover_q_r <= recover_mem[rd_addr];
    deg_q_r     <= deg_mem[rd_addr];
    nbr_q_r     <= nbr_mem[nbr_rd_addr];
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r      <= '0;
      dvld_q_r    <= 1'b0;
      cur_r       <= '0;
      next_r      <= '0;
      cursor_r    <= '0;
      edge_r      <= '0;
      caught_r    <= 1'b0;
      active_r    <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dvld_q_r <= dvld_r[rd_addr];
      if (cmd.load || cmd.emit_err || cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        dvld_r[ndi]       <= 1'b1;
        cur_r[ndi]        <= item_r.initial_state;
        out_r.kind        <= KIND_ACK;
        out_r.result_node <= item_r.node;
        out_r.new_state   <= item_r.initial_state;
        out_r.last_of_round <= 1'b0;
        out_r.any_infected  <= 1'b0;
      end
      if (cmd.edge_wr) begin
        dvld_r[ndi] <= 1'b1;
      end
      if (cmd.emit_err) begin
        out_r.kind          <= KIND_ERR;
        out_r.result_node   <= (item_r.opcode == OP_DRAW) ? '0 : item_r.node;
        out_r.new_state     <= 1'b0;
        out_r.last_of_round <= 1'b0;
        out_r.any_infected  <= 1'b0;
      end
      if (cmd.start) begin
        active_r <= 1'b1;
        cursor_r <= '0;
        edge_r   <= '0;
        caught_r <= 1'b0;
        seen_r   <= 1'b0;
      end
      if (cmd.step) begin
        edge_r   <= edge_inc;
        caught_r <= caught_nx;
      end
      if (cmd.finish) begin
        next_r[cursor_r]    <= fin_v;
        edge_r              <= '0;
        caught_r            <= 1'b0;
        seen_r              <= seen_nx;
        out_r.kind          <= KIND_NODE;
        out_r.result_node   <= NODE_FIELD_W'(cursor_r);
        out_r.new_state     <= fin_v;
        out_r.last_of_round <= last;
        out_r.any_infected  <= last & seen_nx;
        if (last) begin
          for (int k = 0; k < MAX_NODES; k++) begin
            if (k < int'(n_act)) begin
              cur_r[k] <= next_mix[k];
            end
          end
          active_r <= 1'b0;
          cursor_r <= '0;
        end else begin
          cursor_r <= cursor_r + NW'(1);
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (int'(cursor_r) < int'(n_act)))
    else $error("node cursor beyond node count");

  a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(edge_r) < MAX_DEGREE)
    else $error("edge cursor beyond degree limit");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (edge_r == '0) && !caught_r)
    else $error("per-node state left over outside a round");

endmodule

@@ rtl/core/sis_epidemic_graph_round.sv @@
`timescale 1ns / 1ps
// SIS epidemic round engine over a stored neighbor graph.
// Input channel (in_valid/in_stall/in_data) carries load, edge, start and
// draw transactions; a transaction is taken when in_valid is high and
// in_stall low. Result channel (out_valid/out_stall/out_data) carries acks,
// errors and per-node results; the receiver holds it by raising out_stall.
// The APB port writes node_count (any address, single register).
// Transactions are handled one at a time. A load, edge or stray draw
// passes through a read state and then an execute state, as does a draw
// that only advances a neighbor. A draw that resolves a node, or a start,
// then skips each following drawless node (susceptible, no neighbors),
// emitting its result. Each step follows a registered read of the node
// tables and neighbor memory. A result sits in one output register; the
// engine keeps working while it waits and only stalls when it must emit a
// second result into a full register. Reset clears the node states, the
// degree valid flags, cursors and the round flag; degree, probability and
// neighbor memories hold garbage until written.
module sis_epidemic_graph_round #(
  parameter int MAX_NODES  = 64,
  parameter int MAX_DEGREE = 64,
  parameter int PROB_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sisr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sisr_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import sisr_pkg::*;

  logic [CNT_CFG_W-1:0] node_count_r;
  sisr_cmd_t            cmd;
  sisr_sts_t            sts;
  logic                 wr_en;

  // Single register: every address decodes to node_count.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr <= 2'd3);
  assign prdata = 32'(node_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RESET;
    end else if (wr_en) begin
      node_count_r <= pwdata[CNT_CFG_W-1:0];
    end
  end

  sisr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sisr_dp #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE),
    .PROB_BITS  (PROB_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .node_count (node_count_r),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
